[design/csb_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, types and helpers of the CMYK sharpen and blend filter.
// No dependencies; all other files but csb_ram import this package.
package csb_pkg;

    localparam int MAX_LINE = 1024;
    localparam int CHANNELS = 4;
    localparam int CH_W     = 8;
    localparam int PX_W     = CHANNELS * CH_W;
    localparam int ADDR_W   = $clog2(MAX_LINE);

    localparam int LEN_W  = 11;
    localparam int CNT_W  = 16;
    localparam int BIAS_W = 9;
    localparam int AMT_W  = 9;
    localparam int PIX_W  = 10;

    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    // Result queue: up to three per word, at most one drained per cycle.
    localparam int MAX_RES = 3;
    localparam int Q_DEPTH = 8;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // Sharpen sum: 9*255 + 255 down to -8*255 - 256 fits in 13 signed bits.
    localparam int SUM_W = 13;
    // Blend sum: (256-a)*c + a*s stays below 2^16.
    localparam int BL_W  = 17;

    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1024);
    localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(1024);
    localparam logic [AMT_W-1:0] AMT_FULL  = AMT_W'(256);

    typedef enum logic [1:0] {
        REG_LINE_LENGTH,
        REG_LINE_COUNT,
        REG_BIAS,
        REG_BLEND_AMOUNT
    } t_reg_idx;

    typedef logic [PX_W-1:0] t_pixel;
    typedef t_pixel [8:0]    t_window;

    typedef struct packed {
        logic [ADDR_W-1:0]        last_col;
        logic [CNT_W-1:0]         last_row;
        logic signed [BIAS_W-1:0] bias;
        logic [AMT_W-1:0]         amount;
        logic                     restart;
    } t_cfg;

    // Which results a word produces and where it sits in the image.
    typedef struct packed {
        logic              a_en;
        logic              a_sharp;
        logic              b_en;
        logic              c_en;
        logic              last;
        logic [CNT_W-1:0]  row;
        logic [ADDR_W-1:0] col;
    } t_job;

    typedef struct packed {
        t_pixel           px;
        logic [CNT_W-1:0] line;
        logic [PIX_W-1:0] pos;
        logic             last;
    } t_result;

    typedef struct packed {
        logic [MAX_RES-1:0]    en;
        t_result [MAX_RES-1:0] res;
    } t_push;

    function automatic logic [CH_W-1:0] chan_of(input t_pixel px, input int ch);
        return px[ch*CH_W +: CH_W];
    endfunction

endpackage

[design/csb_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; used for both line stores.
module csb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[design/csb_cfg.sv]
`timescale 1ns / 1ps
// APB register file: geometry, bias and blend amount, with effective values.
// Depends on csb_pkg.
module csb_cfg import csb_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic [APB_AW-1:0] i_paddr,
    input  logic [APB_DW-1:0] i_pwdata,
    output logic [APB_DW-1:0] o_prdata,
    output t_cfg              o_cfg
);

    logic [LEN_W-1:0]  r_len;
    logic [CNT_W-1:0]  r_cnt;
    logic [BIAS_W-1:0] r_bias;
    logic [AMT_W-1:0]  r_amt;
    logic              wr;
    t_reg_idx          idx;

    assign wr  = i_psel & i_penable & i_pwrite;
    assign idx = t_reg_idx'(i_paddr[APB_AW-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= LEN_RESET;
            r_cnt  <= CNT_RESET;
            r_bias <= '0;
            r_amt  <= AMT_FULL;
        end else if (wr) begin
            unique case (idx)
                REG_LINE_LENGTH:  r_len  <= i_pwdata[LEN_W-1:0];
                REG_LINE_COUNT:   r_cnt  <= i_pwdata[CNT_W-1:0];
                REG_BIAS:         r_bias <= i_pwdata[BIAS_W-1:0];
                REG_BLEND_AMOUNT: r_amt  <= i_pwdata[AMT_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_LINE_LENGTH:  o_prdata = APB_DW'(r_len);
            REG_LINE_COUNT:   o_prdata = APB_DW'(r_cnt);
            REG_BIAS:         o_prdata = APB_DW'(r_bias);
            REG_BLEND_AMOUNT: o_prdata = APB_DW'(r_amt);
        endcase
    end

    // Lengths are clamped to 3..MAX_LINE, counts to at least 3, blend to 256.
    always_comb begin
        int len;
        len = int'(r_len);
        if (len < 3) begin
            len = 3;
        end
        if (len > MAX_LINE) begin
            len = MAX_LINE;
        end
        o_cfg.last_col = ADDR_W'(len - 1);
        o_cfg.last_row = (r_cnt < CNT_W'(3)) ? CNT_W'(2) : r_cnt - CNT_W'(1);
        o_cfg.bias     = $signed(r_bias);
        o_cfg.amount   = (r_amt > AMT_FULL) ? AMT_FULL : r_amt;
        o_cfg.restart  = wr && (idx == REG_LINE_LENGTH || idx == REG_LINE_COUNT);
    end

endmodule

[design/csb_scan.sv]
`timescale 1ns / 1ps
// Raster position counters, the two line stores and the 3x3 window register.
// Depends on csb_pkg and csb_ram.
module csb_scan import csb_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_accept,
    input  t_pixel     i_px,
    output logic [1:0] o_n_res,
    output t_window    o_window,
    output logic       o_job_valid,
    output t_job       o_job
);

    logic [ADDR_W-1:0] r_col;
    logic [ADDR_W-1:0] n_col;
    logic [ADDR_W-1:0] col;
    logic [CNT_W-1:0]  r_row;
    logic [CNT_W-1:0]  n_row;
    logic [CNT_W-1:0]  row;
    logic              col_last;
    logic              row_last;
    t_job              job;

    logic   r_s1_valid;
    t_job   r_s1_job;
    t_pixel r_s1_px;
    logic   r_s2_valid;
    t_job   r_s2_job;

    t_window r_window;
    t_pixel  prev_rd;
    t_pixel  older_rd;

    assign col      = (r_col > i_cfg.last_col) ? i_cfg.last_col : r_col;
    assign row      = (r_row > i_cfg.last_row) ? i_cfg.last_row : r_row;
    assign col_last = (col == i_cfg.last_col);
    assign row_last = (row == i_cfg.last_row);

    // Line 0 emits its pixels, line 1 none; from line 2 on, words emit the
    // delayed pixel above, that line's end, and on the last line their own.
    always_comb begin
        job.a_en    = (row > CNT_W'(1)) && (col != '0);
        job.a_sharp = (col > ADDR_W'(1));
        job.b_en    = (row > CNT_W'(1)) && col_last;
        job.c_en    = (row == '0) || row_last;
        job.last    = row_last && col_last;
        job.row     = row;
        job.col     = col;
        o_n_res     = 2'(job.a_en) + 2'(job.b_en) + 2'(job.c_en);
    end

    always_comb begin
        if (col_last) begin
            n_col = '0;
            n_row = row_last ? '0 : row + CNT_W'(1);
        end else begin
            n_col = col + ADDR_W'(1);
            n_row = row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (i_cfg.restart) begin
                r_col <= '0;
                r_row <= '0;
            end else if (i_accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            r_s1_valid <= i_accept;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_job <= job;
            r_s1_px  <= i_px;
        end
        if (r_s1_valid) begin
            r_s2_job <= r_s1_job;
            r_window <= {r_s1_px, r_window[8:7], prev_rd, r_window[5:4],
                         older_rd, r_window[2:1]};
        end
    end

    // Both stores are read at the accept edge and written in the next cycle;
    // the older store takes what the newer one held at that column.
    csb_ram #(.WIDTH(PX_W), .DEPTH(MAX_LINE)) u_prev (
        .i_clk     (i_clk),
        .i_wr_en   (r_s1_valid),
        .i_wr_addr (r_s1_job.col),
        .i_wr_data (r_s1_px),
        .i_rd_en   (i_accept),
        .i_rd_addr (col),
        .o_rd_data (prev_rd)
    );

    csb_ram #(.WIDTH(PX_W), .DEPTH(MAX_LINE)) u_older (
        .i_clk     (i_clk),
        .i_wr_en   (r_s1_valid),
        .i_wr_addr (r_s1_job.col),
        .i_wr_data (prev_rd),
        .i_rd_en   (i_accept),
        .i_rd_addr (col),
        .o_rd_data (older_rd)
    );

    assign o_window    = r_window;
    assign o_job_valid = r_s2_valid;
    assign o_job       = r_s2_job;

endmodule

[design/csb_sharpen.sv]
`timescale 1ns / 1ps
// Sharpen kernel with clamp (registered), then the blend with the center
// pixel that builds up to three results per word. Depends on csb_pkg.
module csb_sharpen import csb_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  t_window i_window,
    input  logic    i_job_valid,
    input  t_job    i_job,
    output t_push   o_push
);

    logic   r_valid;
    t_job   r_job;
    t_pixel r_sharp;
    t_pixel r_ctr;
    t_pixel r_right;
    t_pixel r_new;
    t_pixel sharp;
    t_pixel blend;

    function automatic logic signed [SUM_W-1:0] widen(input logic [CH_W-1:0] v);
        return $signed({{(SUM_W-CH_W){1'b0}}, v});
    endfunction

    always_comb begin
        logic signed [SUM_W-1:0] acc;
        logic signed [SUM_W-1:0] ctr;
        sharp = '0;
        for (int ch = 0; ch < CHANNELS; ch++) begin
            ctr = widen(chan_of(i_window[4], ch));
            acc = (ctr <<< 3) + ctr + SUM_W'(i_cfg.bias);
            for (int k = 0; k < 9; k++) begin
                if (k != 4) begin
                    acc = acc - widen(chan_of(i_window[k], ch));
                end
            end
            if (acc < 0) begin
                sharp[ch*CH_W +: CH_W] = '0;
            end else if (acc > SUM_W'(255)) begin
                sharp[ch*CH_W +: CH_W] = '1;
            end else begin
                sharp[ch*CH_W +: CH_W] = acc[CH_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_job_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_job_valid) begin
            r_job   <= i_job;
            r_sharp <= sharp;
            r_ctr   <= i_window[4];
            r_right <= i_window[5];
            r_new   <= i_window[8];
        end
    end

    always_comb begin
        logic [AMT_W-1:0] inv;
        logic [BL_W-1:0]  mix;
        inv   = AMT_FULL - i_cfg.amount;
        blend = '0;
        for (int ch = 0; ch < CHANNELS; ch++) begin
            mix = BL_W'(inv) * BL_W'(chan_of(r_ctr, ch))
                + BL_W'(i_cfg.amount) * BL_W'(chan_of(r_sharp, ch));
            blend[ch*CH_W +: CH_W] = mix[CH_W +: CH_W];
        end
    end

    // Result order within a word: delayed pixel, end of line above, own pixel.
    always_comb begin
        o_push.en = r_valid ? {r_job.c_en, r_job.b_en, r_job.a_en} : '0;

        o_push.res[0].px   = r_job.a_sharp ? blend : r_ctr;
        o_push.res[0].line = r_job.row - CNT_W'(1);
        o_push.res[0].pos  = PIX_W'(r_job.col - ADDR_W'(1));
        o_push.res[0].last = 1'b0;

        o_push.res[1].px   = r_right;
        o_push.res[1].line = r_job.row - CNT_W'(1);
        o_push.res[1].pos  = PIX_W'(r_job.col);
        o_push.res[1].last = 1'b0;

        o_push.res[2].px   = r_new;
        o_push.res[2].line = r_job.row;
        o_push.res[2].pos  = PIX_W'(r_job.col);
        o_push.res[2].last = r_job.last;
    end

endmodule

[design/csb_outq.sv]
`timescale 1ns / 1ps
// Result queue with slot reservation, output register and running maximum.
// Depends on csb_pkg.
module csb_outq import csb_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_push      i_push,
    input  logic       i_accept,
    input  logic [1:0] i_n_res,
    input  logic       i_ready,
    output logic       o_ready,
    output logic       o_valid,
    output t_result    o_res,
    output logic [CH_W-1:0] o_max
);

    t_result           r_q [Q_DEPTH];
    logic [Q_AW:0]     r_wp;
    logic [Q_AW:0]     r_rp;
    logic [Q_AW:0]     r_used;
    logic [Q_AW:0]     n_used;
    logic [Q_AW:0]     wp_b;
    logic [Q_AW:0]     wp_c;
    logic [Q_AW:0]     n_push;
    logic              pop;
    logic              r_ovalid;
    t_result           r_ores;
    logic [CH_W-1:0]   r_max;
    logic [CH_W-1:0]   n_max;
    t_result           head;

    assign head   = r_q[r_rp[Q_AW-1:0]];
    assign pop    = (r_wp != r_rp) && (!r_ovalid || i_ready);
    assign wp_b   = r_wp + (Q_AW+1)'(i_push.en[0]);
    assign wp_c   = wp_b + (Q_AW+1)'(i_push.en[1]);
    assign n_push = (Q_AW+1)'(i_push.en[0]) + (Q_AW+1)'(i_push.en[1])
                  + (Q_AW+1)'(i_push.en[2]);

    // Slots are claimed when a word is accepted and freed as results leave,
    // so a word in the pipeline always finds room for all of its results.
    assign n_used  = r_used + (i_accept ? (Q_AW+1)'(i_n_res) : '0)
                   - (Q_AW+1)'(pop);
    assign o_ready = (r_used <= (Q_AW+1)'(Q_DEPTH - MAX_RES));

    always_comb begin
        n_max = r_max;
        for (int ch = 0; ch < CHANNELS; ch++) begin
            if (chan_of(head.px, ch) > n_max) begin
                n_max = chan_of(head.px, ch);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.en[0]) begin
            r_q[r_wp[Q_AW-1:0]] <= i_push.res[0];
        end
        if (i_push.en[1]) begin
            r_q[wp_b[Q_AW-1:0]] <= i_push.res[1];
        end
        if (i_push.en[2]) begin
            r_q[wp_c[Q_AW-1:0]] <= i_push.res[2];
        end
        if (pop) begin
            r_ores <= head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp     <= '0;
            r_rp     <= '0;
            r_used   <= '0;
            r_ovalid <= 1'b0;
            r_max    <= '0;
        end else begin
            r_wp   <= r_wp + n_push;
            r_used <= n_used;
            if (pop) begin
                r_rp     <= r_rp + (Q_AW+1)'(1);
                r_ovalid <= 1'b1;
                r_max    <= n_max;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_valid = r_ovalid;
    assign o_res   = r_ores;
    assign o_max   = r_max;

endmodule

[design/cmyk_sharpen_blend_filter_unit.sv]
`timescale 1ns / 1ps
// CMYK 3x3 sharpen and blend filter for a raster pixel stream.
// Depends on csb_pkg, csb_cfg, csb_scan, csb_sharpen and csb_outq.
//
// Usage:
//   Input words (i_chan_c/m/y/k) arrive in raster order on i_valid/o_ready.
//   Result words leave on o_valid/i_ready, each with its line, pixel index,
//   the running maximum of all bytes sent so far and a flag on the final
//   pixel of the image. Border pixels pass through; interior pixels are
//   sharpened, biased, clamped and blended with the original.
//   The APB port sets line_length (0x0), line_count (0x4), bias (0x8) and
//   blend_amount (0xC); writing either geometry register restarts the image.
//   Write it only while no result is outstanding.
//   Results pass the scan and sharpen registers, queue and output register.
//   Throughput: one word per cycle while results leave at one per cycle;
//   the last line of an image releases up to three results per word, and
//   the single output register then paces the input to one result per cycle.
//   An 8-entry result queue absorbs receiver stalls; o_ready falls once it
//   cannot hold the worst case of three more results.
//   Synchronous reset clears position, queue and running maximum and loads
//   the register defaults; the line stores need no clearing.
module cmyk_sharpen_blend_filter_unit import csb_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [CH_W-1:0]   i_chan_c,
    input  logic [CH_W-1:0]   i_chan_m,
    input  logic [CH_W-1:0]   i_chan_y,
    input  logic [CH_W-1:0]   i_chan_k,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [CH_W-1:0]   o_out_c,
    output logic [CH_W-1:0]   o_out_m,
    output logic [CH_W-1:0]   o_out_y,
    output logic [CH_W-1:0]   o_out_k,
    output logic [CH_W-1:0]   o_running_max,
    output logic [CNT_W-1:0]  o_out_line,
    output logic [PIX_W-1:0]  o_out_pixel,
    output logic              o_last
);

    t_cfg       cfg;
    logic       accept;
    logic       can_take;
    logic [1:0] n_res;
    t_window    window;
    logic       job_valid;
    t_job       job;
    t_push      push;
    t_result    res;

    assign pready  = 1'b1;
    assign o_ready = can_take;
    assign accept  = i_valid & can_take;

    csb_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_cfg     (cfg)
    );

    csb_scan u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_accept    (accept),
        .i_px        ({i_chan_k, i_chan_y, i_chan_m, i_chan_c}),
        .o_n_res     (n_res),
        .o_window    (window),
        .o_job_valid (job_valid),
        .o_job       (job)
    );

    csb_sharpen u_sharpen (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_window    (window),
        .i_job_valid (job_valid),
        .i_job       (job),
        .o_push      (push)
    );

    csb_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_accept (accept),
        .i_n_res  (n_res),
        .i_ready  (i_ready),
        .o_ready  (can_take),
        .o_valid  (o_valid),
        .o_res    (res),
        .o_max    (o_running_max)
    );

    assign o_out_c     = res.px[0*CH_W +: CH_W];
    assign o_out_m     = res.px[1*CH_W +: CH_W];
    assign o_out_y     = res.px[2*CH_W +: CH_W];
    assign o_out_k     = res.px[3*CH_W +: CH_W];
    assign o_out_line  = res.line;
    assign o_out_pixel = res.pos;
    assign o_last      = res.last;

endmodule

[verif/cmyk_sharpen_blend_filter_unit_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for cmyk_sharpen_blend_filter_unit: streams CMYK images
// under several register settings and checks every result word against a predictor.
// Depends on csb_pkg and the RTL of the filter unit.
module cmyk_sharpen_blend_filter_unit_tb;
    import csb_pkg::*;

    localparam int SETTLE_CYCLES = 16;
    localparam int LONG_HOLD     = 80;
    localparam int CYCLE_LIMIT   = 20000;
    localparam int RANDOM_WORDS  = 70;
    localparam int WIDE_WORDS    = 20;

    typedef struct {
        t_pixel            px;
        logic [CH_W-1:0]   peak;
        logic [CNT_W-1:0]  line;
        logic [PIX_W-1:0]  pos;
        logic              last;
    } t_pixel_out;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    logic              i_valid = 1'b0;
    logic              o_ready;
    logic [CH_W-1:0]   i_chan_c = '0;
    logic [CH_W-1:0]   i_chan_m = '0;
    logic [CH_W-1:0]   i_chan_y = '0;
    logic [CH_W-1:0]   i_chan_k = '0;
    logic              o_valid;
    logic              i_ready = 1'b0;
    logic [CH_W-1:0]   o_out_c;
    logic [CH_W-1:0]   o_out_m;
    logic [CH_W-1:0]   o_out_y;
    logic [CH_W-1:0]   o_out_k;
    logic [CH_W-1:0]   o_running_max;
    logic [CNT_W-1:0]  o_out_line;
    logic [PIX_W-1:0]  o_out_pixel;
    logic              o_last;

    cmyk_sharpen_blend_filter_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_chan_c      (i_chan_c),
        .i_chan_m      (i_chan_m),
        .i_chan_y      (i_chan_y),
        .i_chan_k      (i_chan_k),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_c       (o_out_c),
        .o_out_m       (o_out_m),
        .o_out_y       (o_out_y),
        .o_out_k       (o_out_k),
        .o_running_max (o_running_max),
        .o_out_line    (o_out_line),
        .o_out_pixel   (o_out_pixel),
        .o_last        (o_last)
    );

    // Predictor state: line stores, 3x3 window, scan position and running peak.
    bit [PX_W-1:0]     store_prev [MAX_LINE];
    bit [PX_W-1:0]     store_older [MAX_LINE];
    bit [PX_W-1:0]     win [9];
    int                row_ctr = 0;
    int                col_ctr = 0;
    logic [CH_W-1:0]   peak_byte = '0;
    logic [LEN_W-1:0]  len_reg = LEN_RESET;
    logic [CNT_W-1:0]  cnt_reg = CNT_RESET;
    logic [BIAS_W-1:0] bias_reg = '0;
    logic [AMT_W-1:0]  amt_reg = AMT_FULL;

    t_pixel     feed_q [$];
    t_pixel_out expected_pixels_q [$];
    int         words_queued = 0;
    int         words_taken = 0;
    int         random_words = 0;
    int         mismatches = 0;
    int         cycle_ctr = 0;
    int         hold_requests = 0;
    logic       in_fire = 1'b0;

    // Interior pixel (1,1) saturates high and (1,2) saturates low.
    t_pixel corner_img [12] = '{
        32'h0000_0000, 32'hFFFF_FFFF, 32'h8080_8080, 32'h7F7F_7F7F,
        32'h01FE_807F, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFF00_FF00,
        32'h00FF_00FF, 32'h1020_4080, 32'hFFFF_FFFF, 32'h0000_0000
    };
    // Bright center with black neighbors: with the most negative bias the black
    // channel lands one below zero while the others still clip at the top.
    t_pixel glare_img [9] = '{
        32'hFF00_0000, 32'hFF01_0203, 32'hFF10_2030,
        32'hFF00_00FF, 32'hFFFF_FFFF, 32'hFF08_0402,
        32'hFF00_1000, 32'hFF7F_0000, 32'hFF00_0080
    };

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic t_pixel sharpen_center();
        t_pixel res;
        int     ch, k, center, acc, amt, b, v;
        res = '0;
        b = int'(bias_reg);
        if (b >= 256) b -= 512;
        amt = (int'(amt_reg) > 256) ? 256 : int'(amt_reg);
        for (ch = 0; ch < CHANNELS; ch++) begin
            center = int'(win[4][ch*CH_W +: CH_W]);
            acc = 9 * center + b;
            for (k = 0; k < 9; k++) begin
                if (k != 4) acc -= int'(win[k][ch*CH_W +: CH_W]);
            end
            if (acc < 0) acc = 0;
            if (acc > 255) acc = 255;
            v = ((256 - amt) * center + amt * acc) >> 8;
            res[ch*CH_W +: CH_W] = CH_W'(v);
        end
        return res;
    endfunction

    function automatic void emit_pixel(t_pixel px, int line, int pos, logic last);
        t_pixel_out item;
        int         ch;
        for (ch = 0; ch < CHANNELS; ch++) begin
            if (px[ch*CH_W +: CH_W] > peak_byte) peak_byte = px[ch*CH_W +: CH_W];
        end
        item.px   = px;
        item.peak = peak_byte;
        item.line = CNT_W'(line);
        item.pos  = PIX_W'(pos);
        item.last = last;
        expected_pixels_q.push_back(item);
    endfunction

    // Advances the scan by one input word and queues the results it releases.
    function automatic void filter_pixel(t_pixel px);
        int w, l, r, c, i;
        w = (int'(len_reg) < 3) ? 3 : ((int'(len_reg) > MAX_LINE) ? MAX_LINE : int'(len_reg));
        l = (int'(cnt_reg) < 3) ? 3 : int'(cnt_reg);
        r = (row_ctr < l) ? row_ctr : l - 1;
        c = (col_ctr < w) ? col_ctr : w - 1;
        for (i = 0; i < 3; i++) begin
            win[i*3]     = win[i*3 + 1];
            win[i*3 + 1] = win[i*3 + 2];
        end
        win[2] = store_older[c];
        win[5] = store_prev[c];
        win[8] = px;
        store_older[c] = store_prev[c];
        store_prev[c]  = px;
        if (r == 0) begin
            emit_pixel(px, 0, c, 1'b0);
        end else if (r >= 2) begin
            if (c == 1) begin
                emit_pixel(win[4], r - 1, 0, 1'b0);
            end else if (c >= 2) begin
                emit_pixel(sharpen_center(), r - 1, c - 1, 1'b0);
            end
            if (c == w - 1) emit_pixel(win[5], r - 1, c, 1'b0);
            if (r == l - 1) emit_pixel(px, r, c, c == w - 1);
        end
        if (c >= w - 1) begin
            col_ctr = 0;
            row_ctr = (r >= l - 1) ? 0 : r + 1;
        end else begin
            col_ctr = c + 1;
            row_ctr = r;
        end
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Input and output monitor, sampled at the rising edge.
    always @(posedge i_clk) begin
        t_pixel_out want;
        in_fire <= i_valid && o_ready;
        if (i_rst_n && i_valid && o_ready) begin
            filter_pixel({i_chan_k, i_chan_y, i_chan_m, i_chan_c});
            words_taken++;
        end
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_pixels_q.size() == 0) begin
                $display("%0t: unexpected word expected none got line %0d pixel %0d data %0h",
                         $time, o_out_line, o_out_pixel,
                         {o_out_k, o_out_y, o_out_m, o_out_c});
                mismatches++;
            end else begin
                want = expected_pixels_q.pop_front();
                check_field("out_c", 32'(want.px[7:0]), 32'(o_out_c));
                check_field("out_m", 32'(want.px[15:8]), 32'(o_out_m));
                check_field("out_y", 32'(want.px[23:16]), 32'(o_out_y));
                check_field("out_k", 32'(want.px[31:24]), 32'(o_out_k));
                check_field("running_max", 32'(want.peak), 32'(o_running_max));
                check_field("out_line", 32'(want.line), 32'(o_out_line));
                check_field("out_pixel", 32'(want.pos), 32'(o_out_pixel));
                check_field("last", 32'(want.last), 32'(o_last));
            end
        end
    end

    // Sender: bursts of random length separated by random gaps.
    always @(negedge i_clk) begin
        static int burst_left = 0;
        static int gap_left = 0;
        t_pixel px;
        if (!i_valid || in_fire) begin
            if (gap_left > 0) begin
                i_valid <= 1'b0;
                gap_left--;
            end else if (feed_q.size() > 0) begin
                px = feed_q.pop_front();
                i_chan_c <= px[7:0];
                i_chan_m <= px[15:8];
                i_chan_y <= px[23:16];
                i_chan_k <= px[31:24];
                i_valid  <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver: stall pattern changes after random spans; a long hold on request.
    always @(negedge i_clk) begin
        static int hold_left = 0;
        static int hold_served = 0;
        static int rx_span = 0;
        static int rx_mode = 0;
        if (hold_left > 0) begin
            i_ready <= 1'b0;
            hold_left--;
        end else if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left = LONG_HOLD;
            i_ready <= 1'b0;
        end else begin
            if (rx_span == 0) begin
                rx_mode = $urandom_range(0, 3);
                rx_span = $urandom_range(8, 40);
            end else begin
                rx_span--;
            end
            case (rx_mode)
                0: i_ready <= 1'b1;
                1: i_ready <= 1'($urandom_range(0, 1));
                2: i_ready <= ($urandom_range(0, 3) == 0);
                default: i_ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        cycle_ctr <= cycle_ctr + 1;
        if (cycle_ctr > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic write_reg(t_reg_idx idx, logic [APB_DW-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'({idx, 2'b00});
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_LINE_LENGTH: begin
                len_reg = value[LEN_W-1:0];
                row_ctr = 0;
                col_ctr = 0;
            end
            REG_LINE_COUNT: begin
                cnt_reg = value[CNT_W-1:0];
                row_ctr = 0;
                col_ctr = 0;
            end
            REG_BIAS:         bias_reg = value[BIAS_W-1:0];
            REG_BLEND_AMOUNT: amt_reg = value[AMT_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic queue_pixel(t_pixel px);
        feed_q.push_back(px);
        words_queued++;
    endtask

    // Sender pause: everything accepted, every result back, then a short settle.
    task automatic wait_drained();
        while (words_taken != words_queued || expected_pixels_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_pixel random_pixel(int style);
        t_pixel px;
        int     ch;
        px = $urandom;
        for (ch = 0; ch < CHANNELS; ch++) begin
            if (style == 1) px[ch*CH_W +: CH_W] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            if (style == 2) px[ch*CH_W +: CH_W] = CH_W'($urandom_range(100, 140));
        end
        return px;
    endfunction

    task automatic run_random_phase(int phase);
        logic [APB_DW-1:0] len_val, cnt_val, bias_val, amt_val;
        int                images, style, w, l, count, n;
        case ($urandom_range(0, 6))
            0:       len_val = $urandom_range(0, 2);
            1:       len_val = $urandom_range(7, 12);
            default: len_val = $urandom_range(3, 6);
        endcase
        case ($urandom_range(0, 6))
            0:       cnt_val = $urandom_range(0, 2);
            1:       cnt_val = $urandom_range(6, 8);
            default: cnt_val = $urandom_range(3, 5);
        endcase
        case ($urandom_range(0, 7))
            0:       bias_val = 32'h100;
            1:       bias_val = 32'h0FF;
            2:       bias_val = 32'h000;
            default: bias_val = $urandom_range(0, 511);
        endcase
        case ($urandom_range(0, 7))
            0:       amt_val = 0;
            1:       amt_val = 256;
            2:       amt_val = 511;
            default: amt_val = $urandom_range(0, 511);
        endcase
        if (phase == 0) begin
            bias_val = 32'h0FF;
            amt_val  = 0;
        end
        wait_drained();
        write_reg(REG_LINE_LENGTH, len_val);
        write_reg(REG_LINE_COUNT, cnt_val);
        write_reg(REG_BIAS, bias_val);
        write_reg(REG_BLEND_AMOUNT, amt_val);
        w = (len_val < 3) ? 3 : len_val;
        l = (cnt_val < 3) ? 3 : cnt_val;
        images = $urandom_range(1, 2);
        count = images * w * l;
        // Some phases stop mid-image so that the next geometry write restarts it.
        if ($urandom_range(0, 3) == 0) count -= $urandom_range(1, w);
        if (count > RANDOM_WORDS - random_words) count = RANDOM_WORDS - random_words;
        if (phase == 1) hold_requests++;
        style = $urandom_range(0, 2);
        for (n = 0; n < count; n++) begin
            if (n % (w * l) == 0) style = $urandom_range(0, 2);
            queue_pixel(random_pixel(style));
        end
        random_words += count;
    endtask

    initial begin
        int n, phase;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // A few words under the reset geometry; all of them sit on line 0.
        for (n = 0; n < 3; n++) queue_pixel(random_pixel(0));
        wait_drained();

        write_reg(REG_LINE_LENGTH, 4);
        write_reg(REG_LINE_COUNT, 3);
        write_reg(REG_BIAS, 0);
        write_reg(REG_BLEND_AMOUNT, 256);
        foreach (corner_img[i]) queue_pixel(corner_img[i]);
        wait_drained();

        // Geometry below the minimum, most negative bias and an oversized blend.
        write_reg(REG_LINE_LENGTH, 0);
        write_reg(REG_LINE_COUNT, 2);
        write_reg(REG_BIAS, 32'h100);
        write_reg(REG_BLEND_AMOUNT, 511);
        foreach (glare_img[i]) queue_pixel(glare_img[i]);
        wait_drained();

        // Oversized geometry with a receiver hold while words keep coming.
        write_reg(REG_LINE_LENGTH, 2047);
        write_reg(REG_LINE_COUNT, 65535);
        hold_requests++;
        for (n = 0; n < WIDE_WORDS; n++) queue_pixel(random_pixel(n % 3));

        phase = 0;
        while (random_words < RANDOM_WORDS) begin
            run_random_phase(phase);
            phase++;
        end
        wait_drained();

        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

[cmyk_sharpen_blend_filter_unit.f]
design/csb_pkg.sv
design/csb_ram.sv
design/csb_cfg.sv
design/csb_scan.sv
design/csb_sharpen.sv
design/csb_outq.sv
design/cmyk_sharpen_blend_filter_unit.sv
verif/cmyk_sharpen_blend_filter_unit_tb.sv
